// ===== sv/adcseg_pkg.sv =====
// ----------------------------------------------------------------------------
// adcseg_pkg: shared types and constants
// Field widths, reciprocal constants and the seven segment table for the
// averaged adc to seven segment display unit.
// ----------------------------------------------------------------------------
package adcseg_pkg;

	localparam int SAMPLE_W = 10;
	localparam int SPAN_W   = 7;
	localparam int SEG_W    = 7;
	localparam int DEG_W    = 7;
	localparam int DIGIT_W  = 4;
	localparam int PROD_W   = SAMPLE_W + SPAN_W;

	localparam logic [SPAN_W-1:0] SPAN_RESET = 7'd50;
	localparam logic [SPAN_W-1:0] SPAN_MAX   = 7'd99;

	// x / 1023 as (x * FS_RECIP) >> FS_SHIFT, exact for x up to 1023 * 99
	localparam int                FS_SHIFT   = 27;
	localparam int                FS_RECIP_W = 18;
	localparam logic [FS_RECIP_W-1:0] FS_RECIP = 18'd131201;

	// x / 10 as (x * 205) >> 11, exact for x below 1029
	localparam int           TEN_SHIFT   = 11;
	localparam int           TEN_RECIP_W = 8;
	localparam logic [TEN_RECIP_W-1:0] TEN_RECIP = 8'd205;

	typedef enum logic {
		MODE_SAMPLE = 1'b0,
		MODE_TICK   = 1'b1
	} mode_t;

	typedef enum logic {
		DIGIT_UNITS = 1'b0,
		DIGIT_TENS  = 1'b1
	} digit_sel_t;

	// control that travels with each item down the pipeline
	typedef struct packed {
		logic  valid;
		mode_t mode;
		logic  done;   // sample that closed a group
	} stage_ctrl_t;

	// segments on bit0..bit6: b, a, f, g, e, d, c
	function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] seg;
		case (digit)
			4'd0:    seg = 7'h77;
			4'd1:    seg = 7'h41;
			4'd2:    seg = 7'h3B;
			4'd3:    seg = 7'h6B;
			4'd4:    seg = 7'h4D;
			4'd5:    seg = 7'h6E;
			4'd6:    seg = 7'h7E;
			4'd7:    seg = 7'h43;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h4F;
			default: seg = '0;
		endcase
		return seg;
	endfunction

endpackage

// ===== sv/adcseg_accum.sv =====
// ----------------------------------------------------------------------------
// adcseg_accum: input register and sample accumulator
// Registers the incoming item and sums samples in groups, handing the group
// total downstream once a group closes.
// ----------------------------------------------------------------------------
module adcseg_accum #(
	parameter int SAMPLES_PER_AVERAGE = 4,
	parameter int SUM_W = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  adcseg_pkg::mode_t                  in_mode,
	input  logic [adcseg_pkg::SAMPLE_W-1:0]    in_sample,
	output adcseg_pkg::stage_ctrl_t            ctrl_s2,
	output logic [SUM_W-1:0]                   total_s2,
	input  logic                               free_s3
);

	localparam int CNT_W = (SAMPLES_PER_AVERAGE > 1) ? $clog2(SAMPLES_PER_AVERAGE) : 1;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES_PER_AVERAGE - 1);

	logic                            valid_s1;
	adcseg_pkg::mode_t               mode_s1;
	logic [adcseg_pkg::SAMPLE_W-1:0] sample_s1;
	logic [SUM_W-1:0]                sum_q;
	logic [CNT_W-1:0]                count_q;
	logic                            free_s2;
	logic                            free_s1;
	logic                            take_sample;
	logic                            group_done;
	logic [SUM_W-1:0]                total;

	assign free_s2     = !ctrl_s2.valid || free_s3;
	assign free_s1     = !valid_s1 || free_s2;
	assign in_ready    = free_s1;
	assign take_sample = valid_s1 && free_s2 && (mode_s1 == adcseg_pkg::MODE_SAMPLE);
	assign group_done  = (count_q == CNT_LAST);
	assign total       = sum_q + SUM_W'(sample_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctrl_s2  <= '0;
			sum_q    <= '0;
			count_q  <= '0;
		end else begin
			if (free_s1) begin
				valid_s1 <= in_valid;
			end
			if (free_s2) begin
				ctrl_s2.valid <= valid_s1;
				ctrl_s2.mode  <= mode_s1;
				ctrl_s2.done  <= group_done;
			end
			if (take_sample) begin
				if (group_done) begin
					sum_q   <= '0;
					count_q <= '0;
				end else begin
					sum_q   <= total;
					count_q <= count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s1 && in_valid) begin
			mode_s1   <= in_mode;
			sample_s1 <= in_sample;
		end
		if (free_s2) begin
			total_s2 <= total;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_LAST)
		else $error("sample count past group size");
`endif

endmodule

// ===== sv/adcseg_scale.sv =====
// ----------------------------------------------------------------------------
// adcseg_scale: average and span scaling
// Divides the group total by the group size through a reciprocal multiply,
// then multiplies the average by the span, one multiply per stage.
// ----------------------------------------------------------------------------
module adcseg_scale #(
	parameter int SAMPLES_PER_AVERAGE = 4,
	parameter int SUM_W = 12
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  adcseg_pkg::stage_ctrl_t           ctrl_s2,
	input  logic [SUM_W-1:0]                  total_s2,
	output logic                              free_s3,
	input  logic [adcseg_pkg::SPAN_W-1:0]     span,
	output adcseg_pkg::stage_ctrl_t           ctrl_s4,
	output logic [adcseg_pkg::PROD_W-1:0]     prod_s4,
	input  logic                              free_s5
);

	// exact for totals below 2^19 / group size^2 margin, covers groups up to 16
	localparam int RECIP_SHIFT = 19;
	localparam int RECIP_W     = RECIP_SHIFT + 1;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'((2 ** RECIP_SHIFT + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);
	localparam int QP_W = SUM_W + RECIP_W;

	adcseg_pkg::stage_ctrl_t         ctrl_s3;
	logic [adcseg_pkg::SAMPLE_W-1:0] avg_s3;
	logic [QP_W-1:0]                 quot_full;
	logic [adcseg_pkg::PROD_W-1:0]   prod;
	logic                            free_s4;

	assign free_s4   = !ctrl_s4.valid || free_s5;
	assign free_s3   = !ctrl_s3.valid || free_s4;
	assign quot_full = QP_W'(total_s2) * QP_W'(RECIP);
	assign prod      = adcseg_pkg::PROD_W'(avg_s3) * adcseg_pkg::PROD_W'(span);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
		end else begin
			if (free_s3) begin
				ctrl_s3 <= ctrl_s2;
			end
			if (free_s4) begin
				ctrl_s4 <= ctrl_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free_s3) begin
			avg_s3 <= quot_full[RECIP_SHIFT +: adcseg_pkg::SAMPLE_W];
		end
		if (free_s4) begin
			prod_s4 <= prod;
		end
	end

endmodule

// ===== sv/adcseg_digit.sv =====
// ----------------------------------------------------------------------------
// adcseg_digit: display value and digit output
// Turns a closed group into degrees and holds it; each tick encodes one digit
// of the held value into the output register, alternating units and tens.
// ----------------------------------------------------------------------------
module adcseg_digit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  adcseg_pkg::stage_ctrl_t           ctrl_s4,
	input  logic [adcseg_pkg::PROD_W-1:0]     prod_s4,
	output logic                              free_s5,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [adcseg_pkg::SEG_W-1:0]      out_segments,
	output adcseg_pkg::digit_sel_t            out_digit_select,
	output logic [adcseg_pkg::DEG_W-1:0]      out_shown_degrees
);

	localparam int DP_W = adcseg_pkg::PROD_W + adcseg_pkg::FS_RECIP_W;
	localparam int TP_W = adcseg_pkg::DEG_W + adcseg_pkg::TEN_RECIP_W;

	logic [adcseg_pkg::DEG_W-1:0]   display_q;
	adcseg_pkg::digit_sel_t         high_q;
	logic [DP_W-1:0]                deg_full;
	logic [TP_W-1:0]                tens_full;
	logic [adcseg_pkg::DIGIT_W-1:0] tens;
	logic [adcseg_pkg::DEG_W-1:0]   tens_x10;
	logic [adcseg_pkg::DIGIT_W-1:0] units;
	logic [adcseg_pkg::DIGIT_W-1:0] digit;
	logic                           out_free;
	logic                           load_out;
	logic                           load_display;

	assign deg_full  = DP_W'(prod_s4) * DP_W'(adcseg_pkg::FS_RECIP);
	assign tens_full = TP_W'(display_q) * TP_W'(adcseg_pkg::TEN_RECIP);
	assign tens      = tens_full[adcseg_pkg::TEN_SHIFT +: adcseg_pkg::DIGIT_W];
	assign tens_x10  = {tens, 3'b000} + {2'b00, tens, 1'b0};
	assign units     = adcseg_pkg::DIGIT_W'(display_q - tens_x10);
	assign digit     = (high_q == adcseg_pkg::DIGIT_TENS) ? tens : units;

	assign out_free     = !out_valid || out_ready;
	assign load_out     = ctrl_s4.valid && (ctrl_s4.mode == adcseg_pkg::MODE_TICK) && out_free;
	assign load_display = ctrl_s4.valid && (ctrl_s4.mode == adcseg_pkg::MODE_SAMPLE)
		&& ctrl_s4.done;
	// samples leave here at once, ticks wait for the output register
	assign free_s5      = (ctrl_s4.mode == adcseg_pkg::MODE_SAMPLE) || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			display_q <= '0;
			high_q    <= adcseg_pkg::DIGIT_UNITS;
		end else begin
			if (load_out) begin
				out_valid <= 1'b1;
				high_q    <= (high_q == adcseg_pkg::DIGIT_TENS) ?
					adcseg_pkg::DIGIT_UNITS : adcseg_pkg::DIGIT_TENS;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			if (load_display) begin
				display_q <= deg_full[adcseg_pkg::FS_SHIFT +: adcseg_pkg::DEG_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_segments      <= adcseg_pkg::seg_encode(digit);
			out_digit_select  <= high_q;
			out_shown_degrees <= display_q;
		end
	end

`ifndef SYNTHESIS
	a_display_range: assert property (@(posedge clk) disable iff (!arst_n)
		display_q <= 7'd99)
		else $error("display value beyond two digits");

	a_digit_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (high_q != $past(high_q)))
		else $error("digit select did not alternate");
`endif

endmodule

// ===== sv/adc_average_to_seven_segment_unit.sv =====
// ----------------------------------------------------------------------------
// adc_average_to_seven_segment_unit: averaged adc reading on two digits
// Averages adc samples in groups, scales the average to degrees and drives
// a multiplexed two digit seven segment display one digit per refresh tick.
// ----------------------------------------------------------------------------
// usage
//  - s_axis carries items: tuser 0 is an adc sample in tdata, tuser 1 is a
//    refresh tick (tdata ignored)
//  - every SAMPLES_PER_AVERAGE samples the truncated average times the span,
//    divided by 1023, becomes the shown value; samples give no transfer out
//  - each tick gives one m_axis transfer: segments of one digit, the digit
//    select in tuser (units first after reset, then alternating) and the
//    shown value
//  - cfg_valid writes the span (degrees at full scale); values above 99 are
//    held at 99; cfg_ready is always high, write only while the unit is idle
//  - one item accepted per cycle while s_axis_tready is high; a tick passes
//    through the four stage pipeline (input register, group total, average
//    multiply, span multiply) and then the output register to m_axis
//  - items stay in order, so a tick always shows every group closed ahead
//  - when m_axis stalls, samples ahead of the first waiting tick drain; that
//    tick holds at the last stage and the items behind it back up stage by
//    stage until s_axis_tready drops
//  - reset: shown value 0, span 50, empty group, units digit next
// ----------------------------------------------------------------------------
module adc_average_to_seven_segment_unit #(
	parameter int SAMPLES_PER_AVERAGE = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [9:0] sample, rest zero
	input  logic        s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] segments, [13:7] shown_degrees, rest zero
	output logic        m_axis_tuser,   // [0] digit_select
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data        // [6:0] temp_span
);

	// group total must hold SAMPLES_PER_AVERAGE full scale samples
	localparam int SUM_W = $clog2(SAMPLES_PER_AVERAGE * 1023 + 1);

	logic [adcseg_pkg::SPAN_W-1:0] span_q;
	adcseg_pkg::mode_t             in_mode;
	adcseg_pkg::stage_ctrl_t       ctrl_s2;
	adcseg_pkg::stage_ctrl_t       ctrl_s4;
	logic [SUM_W-1:0]              total_s2;
	logic [adcseg_pkg::PROD_W-1:0] prod_s4;
	logic                          free_s3;
	logic                          free_s5;
	logic [adcseg_pkg::SEG_W-1:0]  segments;
	adcseg_pkg::digit_sel_t        digit_select;
	logic [adcseg_pkg::DEG_W-1:0]  shown_degrees;

	assign in_mode   = adcseg_pkg::mode_t'(s_axis_tuser);
	assign cfg_ready = 1'b1;

	// span register, saturated so the shown value fits two digits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= adcseg_pkg::SPAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			span_q <= (cfg_data > adcseg_pkg::SPAN_MAX) ? adcseg_pkg::SPAN_MAX : cfg_data;
		end
	end

	adcseg_accum #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
		.SUM_W(SUM_W)
	) u_accum (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.in_mode(in_mode),
		.in_sample(s_axis_tdata[adcseg_pkg::SAMPLE_W-1:0]),
		.ctrl_s2(ctrl_s2),
		.total_s2(total_s2),
		.free_s3(free_s3)
	);

	adcseg_scale #(
		.SAMPLES_PER_AVERAGE(SAMPLES_PER_AVERAGE),
		.SUM_W(SUM_W)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl_s2(ctrl_s2),
		.total_s2(total_s2),
		.free_s3(free_s3),
		.span(span_q),
		.ctrl_s4(ctrl_s4),
		.prod_s4(prod_s4),
		.free_s5(free_s5)
	);

	adcseg_digit u_digit (
		.clk(clk),
		.arst_n(arst_n),
		.ctrl_s4(ctrl_s4),
		.prod_s4(prod_s4),
		.free_s5(free_s5),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_segments(segments),
		.out_digit_select(digit_select),
		.out_shown_degrees(shown_degrees)
	);

	// result packing, first field lowest
	assign m_axis_tdata = {2'b00, shown_degrees, segments};
	assign m_axis_tuser = digit_select;

`ifndef SYNTHESIS
	a_span_range: assert property (@(posedge clk) disable iff (!arst_n)
		span_q <= adcseg_pkg::SPAN_MAX)
		else $error("span beyond two digit range");

	a_span_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |=> (span_q == (($past(cfg_data) > adcseg_pkg::SPAN_MAX) ?
			adcseg_pkg::SPAN_MAX : $past(cfg_data))))
		else $error("span write not taken");
`endif

endmodule
